>>> hw/rtl/stac_pkg.sv
`timescale 1ns / 1ps
package stac_pkg;

    localparam int SHADOW_BYTES_DEF = 65536;

    localparam logic [3:0] TAG_UNINIT = 4'hC;
    localparam logic [3:0] TAG_RRZ    = 4'hD;
    localparam logic [3:0] TAG_LRZ    = 4'hE;
    localparam logic [3:0] TAG_FREE   = 4'hF;

    localparam logic [2:0] CMD_CHECK    = 3'd0;
    localparam logic [2:0] CMD_POISON   = 3'd1;
    localparam logic [2:0] CMD_UNPOISON = 3'd2;
    localparam logic [2:0] CMD_PUSH     = 3'd3;
    localparam logic [2:0] CMD_POP      = 3'd4;
    localparam logic [2:0] CMD_CLEAR    = 3'd5;
    localparam logic [2:0] CMD_INIT     = 3'd6;

    localparam logic [0:0] REG_WINDOW_BASE = 1'd0;
    localparam logic [0:0] REG_HALT_ON_ERR = 1'd1;

    localparam logic [2:0] BUG_NONE    = 3'd0;
    localparam logic [2:0] BUG_FREED   = 3'd1;
    localparam logic [2:0] BUG_LRZ     = 3'd2;
    localparam logic [2:0] BUG_RRZ     = 3'd3;
    localparam logic [2:0] BUG_UNINIT  = 3'd4;
    localparam logic [2:0] BUG_PARTIAL = 3'd5;
    localparam logic [2:0] BUG_UNKNOWN = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_READ,
        ST_EVAL,
        ST_TAG,
        ST_DONE
    } state_t;

    function automatic logic [2:0] classify(input logic [3:0] t);
        logic [2:0] c;
        case (t) inside
            TAG_FREE:    c = BUG_FREED;
            TAG_LRZ:     c = BUG_LRZ;
            TAG_RRZ:     c = BUG_RRZ;
            TAG_UNINIT:  c = BUG_UNINIT;
            [4'd1:4'd3]: c = BUG_PARTIAL;
            default:     c = BUG_UNKNOWN;
        endcase
        return c;
    endfunction

endpackage

>>> hw/rtl/stac_shadow_ram.sv
`timescale 1ns / 1ps
module stac_shadow_ram #(
    parameter int DEPTH = 65536,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);
    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> hw/rtl/shadow_tag_access_checker.sv
`timescale 1ns / 1ps
// shadow tag access checker
// a command item (cmd, address, length, tag, write_access) enters on the in
// channel (in_valid / in_ready); exactly one result item per command leaves
// on the out channel (out_valid / out_ready). commands run one at a time.
// a check or region command walks its granules through the shadow ram, each
// in a read state then an eval state (region commands modify and write back
// there); a failing check ends the walk and passes a tag state before done.
// suppress, clear and disabled commands answer directly from idle, with no walk.
// init sweeps the whole store, one shadow byte per cycle, and no item is
// accepted during the sweep.
// the result sits in an output register; when the receiver stalls it holds
// and the next item is taken only after it leaves.
// reset clears control state, the error count, suppress depth, halt and the
// initialized flag; the shadow store is undefined until the first init.
// configuration (window_base, halt_on_error) is written through cfg_we /
// cfg_index / cfg_data; writing it only while idle is up to the user, the block does not enforce it.
module shadow_tag_access_checker
    import stac_pkg::*;
#(
    parameter int SHADOW_BYTES = SHADOW_BYTES_DEF,
    localparam int AW = $clog2(SHADOW_BYTES)
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  cmd,
    input  logic [31:0] address,
    input  logic [23:0] length,
    input  logic [3:0]  tag,
    input  logic        write_access,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        access_ok,
    output logic        violation,
    output logic [2:0]  bug_class,
    output logic [3:0]  start_tag,
    output logic        was_write,
    output logic [31:0] error_total,
    output logic        halted,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    // window spans SHADOW_BYTES*8 bytes, positions held in 34 bits
    localparam int PW = 34;
    localparam logic [PW-1:0] WIN_SPAN = PW'(SHADOW_BYTES) << 3;

    state_t state_reg, state_next;

    logic [31:0] window_base_reg;
    logic        halt_on_error_reg;
    logic        initialized_reg;
    logic [15:0] suppress_reg;
    logic [31:0] err_reg;
    logic        halt_reg;

    // command being worked on
    logic [2:0]    op_reg;
    logic [3:0]    tag_reg;
    logic          wr_reg;
    logic [PW-1:0] cur_reg, cur_next;     // byte position within walk
    logic [PW-1:0] end_reg;               // exclusive end, window relative
    logic          fail_reg, fail_next;
    logic [AW-1:0] clr_reg;
    logic [AW-1:0] start_idx_reg;
    logic          start_hi_reg;

    // output registers
    logic        ov_reg;
    logic        ok_reg, viol_reg, ww_reg;
    logic [2:0]  cls_reg;
    logic [3:0]  stag_reg;

    // ram port
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_wdata, ram_rdata;

    stac_shadow_ram #(.DEPTH(SHADOW_BYTES)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // decode of the incoming item, window relative
    logic [PW-1:0] wlo, a_abs, e_abs, a_rel, e_rel, s_clip, e_clip;
    logic          in_win_a, in_win_e, region_hit, accept, active;

    assign wlo   = {2'b0, window_base_reg[31:3], 3'b0};
    assign a_abs = {2'b0, address};
    assign e_abs = a_abs + {10'b0, length};
    assign a_rel = a_abs - wlo;
    assign e_rel = e_abs - wlo;
    assign in_win_a = (a_abs >= wlo) && (a_rel < WIN_SPAN);
    // last byte e-1 in window; length nonzero so e_abs > a_abs
    assign in_win_e = (e_abs > wlo) && (e_rel <= WIN_SPAN);
    assign region_hit = (length != 24'd0) && (e_abs > wlo) && (a_abs < wlo + WIN_SPAN);
    assign s_clip = (a_abs < wlo) ? '0 : a_rel;
    assign e_clip = (e_rel > WIN_SPAN) ? WIN_SPAN : e_rel;

    assign accept = in_valid && in_ready;
    assign active = !halt_reg && (initialized_reg || cmd == CMD_INIT);

    // tag of current granule from the registered read
    logic [3:0] cur_tag;
    logic [PW-1:0] g_pos, lim;
    logic [2:0] off;
    assign cur_tag = cur_reg[2] ? ram_rdata[7:4] : ram_rdata[3:0];
    assign g_pos   = {cur_reg[PW-1:2], 2'b00};
    assign off     = {1'b0, cur_reg[1:0]};
    assign lim     = ((end_reg - g_pos) > PW'(4)) ? PW'(4) : (end_reg - g_pos);

    logic gran_bad;
    logic [3:0] new_tag;
    always_comb
    begin
        gran_bad = 1'b0;
        if (cur_tag >= 4'd1 && cur_tag <= 4'd3)
        begin
            gran_bad = ({1'b0, off} >= cur_tag) || (lim > PW'(cur_tag));
        end
        else if (cur_tag != 4'd0)
        begin
            gran_bad = 1'b1;
        end
        if (op_reg == CMD_POISON)
            new_tag = tag_reg;
        else if (g_pos + PW'(4) > end_reg)
            new_tag = 4'(end_reg - g_pos);
        else
            new_tag = 4'd0;
    end

    assign in_ready = (state_reg == ST_IDLE) && !ov_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && active)
                begin
                    if (cmd == CMD_INIT)
                        state_next = ST_CLEAR;
                    else if (cmd == CMD_CHECK && suppress_reg == 16'd0
                             && length != 24'd0 && in_win_a && in_win_e)
                        state_next = ST_READ;
                    else if ((cmd == CMD_POISON || cmd == CMD_UNPOISON) && region_hit
                             && s_clip < e_clip)
                        state_next = ST_READ;
                end
            end
            ST_CLEAR: if (clr_reg == AW'(SHADOW_BYTES - 1)) state_next = ST_IDLE;
            ST_READ:  state_next = ST_EVAL;
            ST_EVAL:
            begin
                if (op_reg == CMD_CHECK && gran_bad)
                    state_next = ST_TAG;
                else if (g_pos + PW'(4) >= end_reg)
                    state_next = ST_DONE;
                else
                    state_next = ST_READ;
            end
            ST_TAG:  state_next = ST_DONE;
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // ram control and walk datapath
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = cur_reg[AW+2:3];
        ram_wdata = cur_reg[2] ? {new_tag, ram_rdata[3:0]} : {ram_rdata[7:4], new_tag};
        ram_raddr = (state_reg == ST_EVAL) ? start_idx_reg : cur_reg[AW+2:3];
        cur_next  = cur_reg;
        fail_next = fail_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = 8'h00;
            end
            ST_EVAL:
            begin
                cur_next = g_pos + PW'(4);
                if (op_reg == CMD_CHECK)
                    fail_next = gran_bad;
                else
                    ram_we = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            window_base_reg   <= '0;
            halt_on_error_reg <= 1'b1;
            initialized_reg   <= 1'b0;
            suppress_reg      <= '0;
            err_reg           <= '0;
            halt_reg          <= 1'b0;
            ov_reg            <= 1'b0;
            clr_reg           <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_WINDOW_BASE: window_base_reg   <= cfg_data;
                    REG_HALT_ON_ERR: halt_on_error_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            if (ov_reg && out_ready)
                ov_reg <= 1'b0;
            if (accept)
            begin
                clr_reg <= '0;
                if (state_next == ST_IDLE)
                    ov_reg <= 1'b1;
                if (active)
                begin
                    case (cmd)
                        CMD_PUSH:  if (suppress_reg != 16'hFFFF) suppress_reg <= suppress_reg + 16'd1;
                        CMD_POP:   if (suppress_reg != 16'd0) suppress_reg <= suppress_reg - 16'd1;
                        CMD_CLEAR: err_reg <= '0;
                        default: ;
                    endcase
                end
            end
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + AW'(1);
                if (state_next == ST_IDLE)
                begin
                    initialized_reg <= 1'b1;
                    ov_reg          <= 1'b1;
                end
            end
            if (state_reg == ST_DONE)
            begin
                ov_reg <= 1'b1;
                if (fail_reg)
                begin
                    if (halt_on_error_reg)
                        halt_reg <= 1'b1;
                    else
                        err_reg <= err_reg + 32'd1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg        <= cmd;
            tag_reg       <= tag;
            wr_reg        <= write_access;
            fail_reg      <= 1'b0;
            start_hi_reg  <= a_rel[2];
            start_idx_reg <= a_rel[AW+2:3];
            if (cmd == CMD_CHECK)
            begin
                cur_reg <= a_rel;
                end_reg <= e_rel;
            end
            else
            begin
                cur_reg <= s_clip;
                end_reg <= e_clip;
            end
            ok_reg   <= 1'b1;
            viol_reg <= 1'b0;
            cls_reg  <= BUG_NONE;
            stag_reg <= 4'd0;
            ww_reg   <= 1'b0;
        end
        else
        begin
            fail_reg <= fail_next;
            cur_reg  <= cur_next;
        end
        if (state_reg == ST_TAG)
        begin
            // start granule tag read during the failing eval cycle
            ok_reg   <= 1'b0;
            viol_reg <= 1'b1;
            stag_reg <= start_hi_reg ? ram_rdata[7:4] : ram_rdata[3:0];
            cls_reg  <= classify(start_hi_reg ? ram_rdata[7:4] : ram_rdata[3:0]);
            ww_reg   <= wr_reg;
        end
    end

    assign out_valid   = ov_reg;
    assign access_ok   = ok_reg;
    assign violation   = viol_reg;
    assign bug_class   = cls_reg;
    assign start_tag   = stag_reg;
    assign was_write   = ww_reg;
    assign error_total = err_reg;
    assign halted      = halt_reg;

    // no new item while a result waits
    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !in_ready)
        else $error("item accepted while result pending");
    // halt is sticky
    assert property (@(posedge clk) disable iff (!rst_n) halted |=> halted)
        else $error("halt flag dropped");
    // a violation always reports a failed access
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && violation) |-> (!access_ok && bug_class != BUG_NONE))
        else $error("violation without class");
    // ram written only while sweeping or walking a region
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_CLEAR || state_reg == ST_EVAL))
        else $error("stray shadow write");
endmodule
